/* rtl/host_string_validator_macros.svh */
// Assertion macros for the host string validator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef HOST_STRING_VALIDATOR_MACROS_SVH
`define HOST_STRING_VALIDATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HSV_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HSV_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/hsv_pkg.sv */
// Shared types and constants for the host string validator.
// No dependencies; imported by every module of the block.
package hsv_pkg;

    // character codes
    localparam logic [7:0] DOT_BYTE    = 8'h2E;
    localparam logic [7:0] HYPHEN_BYTE = 8'h2D;
    localparam logic [7:0] DIGIT_LO    = 8'h30;
    localparam logic [7:0] DIGIT_HI    = 8'h39;
    localparam logic [7:0] UPPER_LO    = 8'h41;
    localparam logic [7:0] UPPER_HI    = 8'h5A;
    localparam logic [7:0] LOWER_LO    = 8'h61;
    localparam logic [7:0] LOWER_HI    = 8'h7A;

    // dotted-quad limits
    localparam logic [8:0] OCTET_MAX  = 9'd255;
    localparam logic [8:0] OCTET_SAT  = 9'd256;
    localparam logic [2:0] QUAD_DOTS  = 3'd3;
    localparam logic [2:0] MAX_DIGITS = 3'd3;
    localparam logic [2:0] DIGITS_SAT = 3'd4;
    localparam logic [2:0] DOTS_SAT   = 3'd7;

    // token queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // classified byte, as passed from front to back
    typedef struct packed {
        logic       is_digit;
        logic       is_alpha;
        logic       is_dot;
        logic       is_hyphen;
        logic [3:0] digit;
        logic       no_char;
        logic       last;
    } token_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* rtl/host_string_validator.sv */
// Top level of the host string validator: front classifier, token queue,
// back-end tracker. Depends on hsv_pkg and host_string_validator_macros.svh.
//
// Usage:
//   Input channel (char_valid / char_stall): one transaction per byte of a
//   host string; no_char marks a transaction without a byte (an empty string
//   is a lone transaction with no_char and last_char set). last_char closes
//   the string.
//   Output channel (verdict_valid / verdict_stall): one transaction per
//   string, carrying host_valid and took_ipv4_path.
//   Throughput: one byte per cycle while the queue is not full; the back end
//   retires one token per cycle from the queue, but holds a last token while
//   a stalled verdict occupies the output register.
//   Verdict path: the last byte's token is registered in the queue, and the
//   verdict is then registered in the output register.
//   The four-entry token queue lets the front keep taking bytes while a
//   verdict waits; char_stall rises only when that queue is full.
//   Reset empties the queue, clears the trackers and drops verdict_valid.
//   When the receiver stalls, the verdict holds and further bytes drain
//   until the next last byte reaches the back end.
`include "host_string_validator_macros.svh"

module host_string_validator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] char_byte,
    input  logic       no_char,
    input  logic       last_char,
    output logic       verdict_valid,
    input  logic       verdict_stall,
    output logic       host_valid,
    output logic       took_ipv4_path
);
    import hsv_pkg::*;

    token_t    in_tok;
    token_t    q_tok;
    q_status_t q_status;
    logic      push;
    logic      back_pop;

    hsv_front u_front (
        .char_byte (char_byte),
        .no_char   (no_char),
        .last_char (last_char),
        .tok       (in_tok)
    );

    // stall comes straight from the queue's full flag
    assign char_stall = q_status.full;
    assign push       = char_valid && !q_status.full;

    hsv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (in_tok),
        .pop      (back_pop),
        .pop_tok  (q_tok),
        .status   (q_status)
    );

    hsv_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .tok            (q_tok),
        .q_status       (q_status),
        .pop            (back_pop),
        .verdict_valid  (verdict_valid),
        .verdict_stall  (verdict_stall),
        .host_valid     (host_valid),
        .took_ipv4_path (took_ipv4_path)
    );

    // queue bookkeeping and token-to-verdict hand-off
    `HSV_ASSERT_IMP(a_q_flags, 1'b1, !(q_status.full && q_status.empty), "queue full and empty")
    `HSV_ASSERT_NXT(a_push_lands, push, !q_status.empty, "pushed token lost")
    `HSV_ASSERT_NXT(a_last_verdict, back_pop && q_tok.last, verdict_valid, "no verdict for last")

endmodule

/* rtl/hsv_front.sv */
// Front end: classifies one input byte into a token.
// Depends on hsv_pkg.
module hsv_front (
    input  logic [7:0]      char_byte,
    input  logic            no_char,
    input  logic            last_char,
    output hsv_pkg::token_t tok
);
    import hsv_pkg::*;

    always_comb
    begin
        tok.is_digit  = char_byte inside {[DIGIT_LO:DIGIT_HI]};
        tok.is_alpha  = char_byte inside {[UPPER_LO:UPPER_HI], [LOWER_LO:LOWER_HI]};
        tok.is_dot    = (char_byte == DOT_BYTE);
        tok.is_hyphen = (char_byte == HYPHEN_BYTE);
        tok.digit     = char_byte[3:0];
        tok.no_char   = no_char;
        tok.last      = last_char;
    end

endmodule

/* rtl/hsv_queue.sv */
// Short token queue between front and back.
// Depends on hsv_pkg (token_t, queue sizing).
module hsv_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hsv_pkg::token_t    push_tok,
    input  logic               pop,
    output hsv_pkg::token_t    pop_tok,
    output hsv_pkg::q_status_t status
);
    import hsv_pkg::*;

    token_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(push);
        rd_ptr_next = rd_ptr_reg + QUEUE_AW'(pop);
        count_next  = count_reg + QUEUE_CW'(push) - QUEUE_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_tok;
        end
    end

    assign pop_tok      = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

/* rtl/hsv_back.sv */
// Back end: runs the quad and hostname trackers on each token and
// registers the verdict. Depends on hsv_pkg.
module hsv_back (
    input  logic               clk,
    input  logic               rst_n,
    input  hsv_pkg::token_t    tok,
    input  hsv_pkg::q_status_t q_status,
    output logic               pop,
    output logic               verdict_valid,
    input  logic               verdict_stall,
    output logic               host_valid,
    output logic               took_ipv4_path
);
    import hsv_pkg::*;

    logic       at_start_reg, at_start_next;
    logic       only_dd_reg, only_dd_next;
    logic [2:0] dot_tally_reg, dot_tally_next;
    logic [2:0] octet_digits_reg, octet_digits_next;
    logic [8:0] octet_value_reg, octet_value_next;
    logic       quad_bad_reg, quad_bad_next;
    logic       name_bad_reg, name_bad_next;
    logic       prev_dot_reg, prev_dot_next;
    logic       prev_hyp_reg, prev_hyp_next;

    logic       out_valid_reg, out_valid_next;
    logic       host_valid_reg, host_valid_next;
    logic       ipv4_reg, ipv4_next;

    // post-byte view of the string
    logic       t_at_start, t_only_dd, t_quad_bad, t_name_bad, t_prev_dot, t_prev_hyp;
    logic [2:0] t_dots, t_digits;
    logic [8:0] t_value;
    logic [11:0] scaled;
    logic       cur_broken, end_broken, out_free, q_bad, n_bad, is_quad;

    always_comb
    begin
        scaled = {octet_value_reg, 3'b000} + {2'b00, octet_value_reg, 1'b0}
                 + {8'h00, tok.digit};
        cur_broken = (octet_digits_reg == '0) || (octet_digits_reg > MAX_DIGITS)
                     || (octet_value_reg > OCTET_MAX);

        t_at_start = at_start_reg;
        t_only_dd  = only_dd_reg;
        t_dots     = dot_tally_reg;
        t_digits   = octet_digits_reg;
        t_value    = octet_value_reg;
        t_quad_bad = quad_bad_reg;
        t_name_bad = name_bad_reg;
        t_prev_dot = prev_dot_reg;
        t_prev_hyp = prev_hyp_reg;

        if (!tok.no_char)
        begin
            if (tok.is_digit)
            begin
                if (octet_digits_reg < DIGITS_SAT)
                begin
                    t_digits = octet_digits_reg + 3'd1;
                end
                t_value = (scaled > {3'b000, OCTET_SAT}) ? OCTET_SAT : scaled[8:0];
            end
            else if (tok.is_dot)
            begin
                t_quad_bad = quad_bad_reg | cur_broken;
                if (dot_tally_reg < DOTS_SAT)
                begin
                    t_dots = dot_tally_reg + 3'd1;
                end
                t_digits = '0;
                t_value  = '0;
            end
            else
            begin
                t_only_dd = 1'b0;
            end

            if (!(tok.is_digit || tok.is_alpha || tok.is_dot || tok.is_hyphen)
                || (at_start_reg && (tok.is_dot || tok.is_hyphen))
                || (tok.is_dot && (prev_dot_reg || prev_hyp_reg))
                || (tok.is_hyphen && prev_dot_reg))
            begin
                t_name_bad = 1'b1;
            end

            t_prev_dot = tok.is_dot;
            t_prev_hyp = tok.is_hyphen;
            t_at_start = 1'b0;
        end

        // verdict on the string as it stands after this token
        end_broken = (t_digits == '0) || (t_digits > MAX_DIGITS) || (t_value > OCTET_MAX);
        q_bad   = t_quad_bad | end_broken;
        n_bad   = t_name_bad | t_prev_dot | t_prev_hyp;
        is_quad = !t_at_start && t_only_dd && (t_dots == QUAD_DOTS);

        out_free = !out_valid_reg || !verdict_stall;
        pop      = !q_status.empty && (!tok.last || out_free);

        at_start_next     = at_start_reg;
        only_dd_next      = only_dd_reg;
        dot_tally_next    = dot_tally_reg;
        octet_digits_next = octet_digits_reg;
        octet_value_next  = octet_value_reg;
        quad_bad_next     = quad_bad_reg;
        name_bad_next     = name_bad_reg;
        prev_dot_next     = prev_dot_reg;
        prev_hyp_next     = prev_hyp_reg;

        if (pop)
        begin
            if (tok.last)
            begin
                // string done: back to the idle view
                at_start_next     = 1'b1;
                only_dd_next      = 1'b1;
                dot_tally_next    = '0;
                octet_digits_next = '0;
                octet_value_next  = '0;
                quad_bad_next     = 1'b0;
                name_bad_next     = 1'b0;
                prev_dot_next     = 1'b0;
                prev_hyp_next     = 1'b0;
            end
            else
            begin
                at_start_next     = t_at_start;
                only_dd_next      = t_only_dd;
                dot_tally_next    = t_dots;
                octet_digits_next = t_digits;
                octet_value_next  = t_value;
                quad_bad_next     = t_quad_bad;
                name_bad_next     = t_name_bad;
                prev_dot_next     = t_prev_dot;
                prev_hyp_next     = t_prev_hyp;
            end
        end

        out_valid_next  = out_valid_reg;
        host_valid_next = host_valid_reg;
        ipv4_next       = ipv4_reg;
        if (out_free)
        begin
            out_valid_next = pop && tok.last;
            if (pop && tok.last)
            begin
                ipv4_next       = is_quad;
                host_valid_next = t_at_start ? 1'b0 : (is_quad ? !q_bad : !n_bad);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg     <= 1'b1;
            only_dd_reg      <= 1'b1;
            dot_tally_reg    <= '0;
            octet_digits_reg <= '0;
            octet_value_reg  <= '0;
            quad_bad_reg     <= 1'b0;
            name_bad_reg     <= 1'b0;
            prev_dot_reg     <= 1'b0;
            prev_hyp_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            at_start_reg     <= at_start_next;
            only_dd_reg      <= only_dd_next;
            dot_tally_reg    <= dot_tally_next;
            octet_digits_reg <= octet_digits_next;
            octet_value_reg  <= octet_value_next;
            quad_bad_reg     <= quad_bad_next;
            name_bad_reg     <= name_bad_next;
            prev_dot_reg     <= prev_dot_next;
            prev_hyp_reg     <= prev_hyp_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        host_valid_reg <= host_valid_next;
        ipv4_reg       <= ipv4_next;
    end

    assign verdict_valid  = out_valid_reg;
    assign host_valid     = host_valid_reg;
    assign took_ipv4_path = ipv4_reg;

endmodule
